// ----- sv/pcxd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared types and constants for the PCX run-length planar decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcxd_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Code byte classification.
  localparam logic [7:0] RUN_MARK_MASK = 8'hC0;
  localparam logic [7:0] RUN_LEN_MASK  = 8'h3F;

  // Largest number of results one input word may cause.
  localparam logic [5:0] MAX_RESULTS = 6'd63;

  localparam logic STATUS_PIXEL = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  typedef struct packed {
    logic        pixel_mode;
    logic [15:0] line_bytes;
    logic [12:0] image_width;
    logic [14:0] image_height;
  } cfg_t;

  // One decoded command handed from the front to the back: a byte value,
  // how many times it is placed, and whether the stream ends with it.
  typedef struct packed {
    logic [7:0] code;
    logic [5:0] count;
    logic       eos;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/pcxd_ram.sv -----
// ----------------------------------------------------------------------------
// pcxd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pcxd_front.sv -----
// ----------------------------------------------------------------------------
// pcxd_front
// Accepts compressed words and turns them into byte/count commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_code_byte,
  input  wire logic                in_stream_end,
  input  wire logic                q_full,
  output logic                     push,
  output pcxd_pkg::cmd_t           push_cmd
);

  logic       await_r, await_nxt;
  logic [5:0] run_len_r, run_len_nxt;
  logic       acc;
  logic       is_mark;

  assign in_stall = q_full;
  assign acc      = in_valid & ~in_stall;
  assign is_mark  = (in_code_byte & pcxd_pkg::RUN_MARK_MASK) == pcxd_pkg::RUN_MARK_MASK;

  always_comb begin
    await_nxt      = await_r;
    run_len_nxt    = run_len_r;
    push           = 1'b0;
    push_cmd.code  = in_code_byte;
    push_cmd.count = 6'd0;
    push_cmd.eos   = in_stream_end;
    if (acc) begin
      if (await_r) begin
        await_nxt      = 1'b0;
        push_cmd.count = run_len_r;
        push           = (run_len_r != 6'd0) | in_stream_end;
      end else if (is_mark) begin
        run_len_nxt    = in_code_byte[5:0] & pcxd_pkg::RUN_LEN_MASK[5:0];
        // A marker that closes the stream only reports truncation.
        await_nxt      = ~in_stream_end;
        push_cmd.count = 6'd0;
        push           = in_stream_end;
      end else begin
        push_cmd.count = 6'd1;
        push           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r   <= 1'b0;
      run_len_r <= 6'd0;
    end else begin
      await_r   <= await_nxt;
      run_len_r <= run_len_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pcxd_queue.sv -----
// ----------------------------------------------------------------------------
// pcxd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  pcxd_pkg::cmd_t      push_cmd,
  output logic                full,
  output logic                head_valid,
  output pcxd_pkg::cmd_t      head_cmd,
  input  wire logic           pop
);

  pcxd_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pcxd_back.sv -----
// ----------------------------------------------------------------------------
// pcxd_back
// Places decoded bytes by plane, column and row, keeps the red and green
// line stores and builds result words with the last-of-word flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_back #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  pcxd_pkg::cfg_t      cfg,
  input  wire logic           q_valid,
  input  pcxd_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_first_value,
  output logic [7:0]          out_green_value,
  output logic [7:0]          out_blue_value,
  output logic [11:0]         out_column,
  output logic [14:0]         out_row_index,
  output logic                out_image_done,
  output logic                out_run_last,
  output logic                out_status
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [15:0] MAXW = 16'(MAX_WIDTH);

  // Placement position.
  logic [15:0] col_r, col_nxt;
  logic [1:0]  plane_r, plane_nxt;
  logic [14:0] row_r, row_nxt;
  logic        fin_r, fin_nxt;

  // Progress on the command at the head of the queue.
  logic        p_busy_r, p_busy_nxt;
  logic        p_err_r, p_err_nxt;
  logic [5:0]  p_cnt_r, p_cnt_nxt;
  logic [5:0]  p_n_r, p_n_nxt;

  // Result hold stage: a result stays here until it is known whether
  // another result of the same word follows it.
  logic        r_valid_r, r_valid_nxt;
  logic        r_closed_r, r_closed_nxt;
  logic        r_blue_r, r_blue_nxt;
  logic [7:0]  r_val_r, r_val_nxt;
  logic [11:0] r_col_r, r_col_nxt;
  logic [14:0] r_row_r, r_row_nxt;
  logic        r_done_r, r_done_nxt;
  logic        r_status_r, r_status_nxt;

  logic        out_valid_r, out_valid_nxt;

  logic [15:0] lb, wi, wm, w;
  logic [14:0] h;
  logic [16:0] col_p1;
  logic        last_col, last_row, last_plane, visible, produce, done, fin_new;
  logic [5:0]  cur_cnt, cur_n, n_new;
  logic        active, do_err, at_max, o_free, r_move, can_enter;
  logic        cand_want, cand_in, rep, place_go, err_go;
  logic        closing, to_err, close_cmd;
  logic        red_we, green_we, line_re;
  logic [7:0]  red_q, green_q;

  // Geometry with out-of-range registers folded in.
  always_comb begin
    lb = (cfg.line_bytes == 16'd0) ? 16'd1 : cfg.line_bytes;
    h  = (cfg.image_height == 15'd0) ? 15'd1 : cfg.image_height;
    wi = (cfg.image_width == 13'd0) ? 16'd1 : {3'b000, cfg.image_width};
    wm = (wi > MAXW) ? MAXW : wi;
    w  = (wm > lb) ? lb : wm;
  end

  always_comb begin
    col_p1     = {1'b0, col_r} + 17'd1;
    last_col   = col_p1 >= {1'b0, lb};
    last_row   = ({1'b0, row_r} + 16'd1) >= {1'b0, h};
    last_plane = ~cfg.pixel_mode | (plane_r >= 2'd2);
    visible    = col_r < w;
    produce    = visible & (~cfg.pixel_mode | (plane_r >= 2'd2));
    done       = last_plane & last_row & (col_p1 == {1'b0, w});
    fin_new    = last_col & last_plane & last_row;
  end

  always_comb begin
    cur_cnt   = p_busy_r ? p_cnt_r : q_cmd.count;
    cur_n     = p_busy_r ? p_n_r : 6'd0;
    do_err    = p_err_r | (~p_busy_r & (q_cmd.count == 6'd0));
    at_max    = cur_n == pcxd_pkg::MAX_RESULTS;
    active    = q_valid & ~fin_r;
    o_free    = ~out_valid_r | ~out_stall;
    cand_want = active & ((do_err & ~at_max) | (~do_err & produce));
    rep       = active & do_err & at_max;
    r_move    = r_valid_r & o_free & (r_closed_r | cand_want);
    can_enter = ~r_valid_r | r_move;
    cand_in   = cand_want & can_enter;
    err_go    = active & do_err & (at_max | can_enter);
    place_go  = active & ~do_err & (~produce | can_enter);
    closing   = place_go & ((cur_cnt == 6'd1) | fin_new);
    to_err    = closing & q_cmd.eos & ~fin_new;
    close_cmd = closing & ~to_err;
    q_pop     = (q_valid & fin_r) | err_go | close_cmd;
    n_new     = cur_n + {5'b00000, produce};
  end

  // Position and command progress.
  always_comb begin
    col_nxt    = col_r;
    plane_nxt  = plane_r;
    row_nxt    = row_r;
    fin_nxt    = fin_r;
    p_busy_nxt = p_busy_r;
    p_err_nxt  = p_err_r;
    p_cnt_nxt  = p_cnt_r;
    p_n_nxt    = p_n_r;
    if (place_go) begin
      if (!last_col) begin
        col_nxt = col_p1[15:0];
      end else begin
        col_nxt = 16'd0;
        if (!last_plane) begin
          plane_nxt = plane_r + 2'd1;
        end else begin
          plane_nxt = 2'd0;
          if (last_row) begin
            fin_nxt = 1'b1;
          end else begin
            row_nxt = row_r + 15'd1;
          end
        end
      end
    end
    if (err_go) begin
      p_busy_nxt = 1'b0;
      p_err_nxt  = 1'b0;
      fin_nxt    = 1'b1;
    end else if (q_valid && fin_r) begin
      p_busy_nxt = 1'b0;
      p_err_nxt  = 1'b0;
    end else if (place_go) begin
      if (to_err) begin
        p_busy_nxt = 1'b1;
        p_err_nxt  = 1'b1;
        p_n_nxt    = n_new;
      end else if (close_cmd) begin
        p_busy_nxt = 1'b0;
      end else begin
        p_busy_nxt = 1'b1;
        p_cnt_nxt  = cur_cnt - 6'd1;
        p_n_nxt    = n_new;
      end
    end
  end

  // Hold stage.
  always_comb begin
    r_valid_nxt  = r_valid_r;
    r_closed_nxt = r_closed_r;
    r_blue_nxt   = r_blue_r;
    r_val_nxt    = r_val_r;
    r_col_nxt    = r_col_r;
    r_row_nxt    = r_row_r;
    r_done_nxt   = r_done_r;
    r_status_nxt = r_status_r;
    if (cand_in || rep) begin
      r_valid_nxt = 1'b1;
      if (do_err) begin
        // The truncation word either follows the pixels or, when the word
        // already gave its full share of results, takes the last one's place.
        r_closed_nxt = 1'b1;
        r_blue_nxt   = 1'b0;
        r_val_nxt    = 8'd0;
        r_col_nxt    = 12'd0;
        r_row_nxt    = 15'd0;
        r_done_nxt   = 1'b0;
        r_status_nxt = pcxd_pkg::STATUS_TRUNC;
      end else begin
        r_closed_nxt = close_cmd;
        r_blue_nxt   = cfg.pixel_mode;
        r_val_nxt    = q_cmd.code;
        r_col_nxt    = col_r[11:0];
        r_row_nxt    = row_r;
        r_done_nxt   = done;
        r_status_nxt = pcxd_pkg::STATUS_PIXEL;
      end
    end else if (r_move) begin
      r_valid_nxt = 1'b0;
    end else if (close_cmd && r_valid_r) begin
      r_closed_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (r_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 16'd0;
      plane_r     <= 2'd0;
      row_r       <= 15'd0;
      fin_r       <= 1'b0;
      p_busy_r    <= 1'b0;
      p_err_r     <= 1'b0;
      p_cnt_r     <= 6'd0;
      p_n_r       <= 6'd0;
      r_valid_r   <= 1'b0;
      r_closed_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      plane_r     <= plane_nxt;
      row_r       <= row_nxt;
      fin_r       <= fin_nxt;
      p_busy_r    <= p_busy_nxt;
      p_err_r     <= p_err_nxt;
      p_cnt_r     <= p_cnt_nxt;
      p_n_r       <= p_n_nxt;
      r_valid_r   <= r_valid_nxt;
      r_closed_r  <= r_closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_blue_r   <= r_blue_nxt;
    r_val_r    <= r_val_nxt;
    r_col_r    <= r_col_nxt;
    r_row_r    <= r_row_nxt;
    r_done_r   <= r_done_nxt;
    r_status_r <= r_status_nxt;
    if (r_move) begin
      out_first_value <= r_blue_r ? red_q : r_val_r;
      out_green_value <= r_blue_r ? green_q : 8'd0;
      out_blue_value  <= r_blue_r ? r_val_r : 8'd0;
      out_column      <= r_col_r;
      out_row_index   <= r_row_r;
      out_image_done  <= r_done_r;
      out_run_last    <= r_closed_r;
      out_status      <= r_status_r;
    end
  end

  assign out_valid = out_valid_r;

  // Line stores. The read data stays put while a blue result waits in the
  // hold stage, since a read is only issued when a new result enters it.
  assign red_we   = place_go & cfg.pixel_mode & visible & (plane_r == 2'd0);
  assign green_we = place_go & cfg.pixel_mode & visible & (plane_r == 2'd1);
  assign line_re  = cand_in & ~do_err & cfg.pixel_mode;

  pcxd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_red_line (
    .clk   (clk),
    .we    (red_we),
    .waddr (col_r[AW-1:0]),
    .wdata (q_cmd.code),
    .re    (line_re),
    .raddr (col_r[AW-1:0]),
    .rdata (red_q)
  );

  pcxd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_green_line (
    .clk   (clk),
    .we    (green_we),
    .waddr (col_r[AW-1:0]),
    .wdata (q_cmd.code),
    .re    (line_re),
    .raddr (col_r[AW-1:0]),
    .rdata (green_q)
  );

  a_rep_holds_open: assert property (@(posedge clk) disable iff (!rst_n)
    rep |-> (r_valid_r && !r_closed_r))
    else $error("result replaced while the hold stage holds no open result");

  a_open_leaves_for_next: assert property (@(posedge clk) disable iff (!rst_n)
    (r_move && !r_closed_r) |-> cand_in)
    else $error("open result left without a following result of its word");

  a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (!place_go && !cand_in && !rep))
    else $error("placement after the image was finished");

  a_err_phase_unfinished: assert property (@(posedge clk) disable iff (!rst_n)
    p_err_r |-> (!fin_r && p_busy_r))
    else $error("truncation pending on a finished image");

endmodule

`default_nettype wire

// ----- sv/pcx_rle_planar_decoder_unit.sv -----
// A literal word reaches the output through the command queue, the hold stage
// and the output register, and is held back while the output is stalled.
// Throughput: the back places one decoded byte per cycle while its output is
// not stalled; a run is placed byte by byte, and a two-entry command queue
// lets the input keep flowing until that placement loop falls behind.
// Reset: synchronous, active low; clears control state and sets the configuration to its defaults.
// The line stores are not cleared and hold nothing valid until written.
// ----------------------------------------------------------------------------
// pcx_rle_planar_decoder_unit
// PCX run-length decoder with planar RGB line assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_planar_decoder_unit #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [pcxd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pcxd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_code_byte,
  input  wire logic                              in_stream_end,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_first_value,
  output logic [7:0]                             out_green_value,
  output logic [7:0]                             out_blue_value,
  output logic [11:0]                            out_column,
  output logic [14:0]                            out_row_index,
  output logic                                   out_image_done,
  output logic                                   out_run_last,
  output logic                                   out_status
);

  pcxd_pkg::cfg_t cfg_r, cfg_nxt;
  pcxd_pkg::cmd_t push_cmd, head_cmd;
  logic           push, q_full, head_valid, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pcxd_pkg::REG_PIXEL_MODE:   cfg_nxt.pixel_mode   = cfg_data[0];
        pcxd_pkg::REG_LINE_BYTES:   cfg_nxt.line_bytes   = cfg_data;
        pcxd_pkg::REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_data[12:0];
        pcxd_pkg::REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_data[14:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode   <= 1'b0;
      cfg_r.line_bytes   <= 16'd1;
      cfg_r.image_width  <= 13'd1;
      cfg_r.image_height <= 15'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pcxd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_byte  (in_code_byte),
    .in_stream_end (in_stream_end),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  pcxd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop)
  );

  pcxd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (head_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_value (out_first_value),
    .out_green_value (out_green_value),
    .out_blue_value  (out_blue_value),
    .out_column      (out_column),
    .out_row_index   (out_row_index),
    .out_image_done  (out_image_done),
    .out_run_last    (out_run_last),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire
